// File: rtl/hte_pkg.sv
// shared constants, command codes and table access types for the huffman table encoder
package hte_pkg;

	localparam int DEF_MAX_CODE_LEN = 24;
	localparam int DEF_SYMBOL_COUNT = 256;

	localparam int CMD_W    = 2;
	localparam int SYM_W    = 8;
	localparam int CODE_W   = 24;
	localparam int LEN_W    = 5;
	localparam int BYTE_W   = 8;
	localparam int PAD_W    = 3;
	localparam int ACC_W    = 7;
	localparam int PEND_W   = 3;
	localparam int WIDE_W   = CODE_W + ACC_W;
	localparam int NBYTE_W  = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

	typedef struct packed {
		logic              en;
		logic [SYM_W-1:0]  idx;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} tbl_wr_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} tbl_rd_t;

endpackage

// File: rtl/hte_if.sv
// valid/ready channel interfaces for the encoder input items and output bytes
interface hte_in_if import hte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SYM_W-1:0]  symbol;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0]  code_length;

	modport source (output valid, command, symbol, code_bits, code_length, input ready);
	modport sink (input valid, command, symbol, code_bits, code_length, output ready);
endinterface

interface hte_out_if import hte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] packed_byte;
	logic [PAD_W-1:0]  pad_count;
	logic              is_final;
	logic              last;

	modport source (output valid, packed_byte, pad_count, is_final, last, input ready);
	modport sink (input valid, packed_byte, pad_count, is_final, last, output ready);
endinterface

// File: rtl/huffman_table_encoder_top.sv
// huffman table encoder: table load, code packing into bytes and flush
//
// in_ch carries one item per transfer: command load writes symbol's code and
// length into the code table, encode appends the symbol's code msb first to the
// bit accumulator, flush emits the pending partial byte zero padded at the low end.
// out_ch carries one byte per transfer, first code bit in bit 7; last marks the
// final byte of an input item, is_final and pad_count mark a flushed byte.
// an item is accepted every cycle while the output keeps up; the table read is
// registered, and the bytes of an item pass the table read stage and then the
// byte buffer before they reach out_ch. an encode that completes k bytes (0 to 3)
// holds the output for k byte transfers, so the byte-wide output port sets the
// sustained rate for items whose codes complete more than one byte.
// the next item is taken while the previous bytes still wait on out_ch.
// reset clears the accumulator, the pipeline and all table entries (length 0),
// with no sweep. a stalled receiver holds the current byte; once the byte buffer
// and the table read stage are full, in_ch.ready drops until bytes drain.
module huffman_table_encoder_top import hte_pkg::*; #(
	parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
	input  logic      clk,
	input  logic      arst_n,
	hte_in_if.sink    in_ch,
	hte_out_if.source out_ch
);

	localparam int LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam logic [LEN_W-1:0] LIM_LEN = LEN_W'(LIM);

	logic              in_xfer;
	logic              out_xfer;
	logic              in_range;
	logic [LEN_W-1:0]  len_sat;
	tbl_wr_t           tbl_wr;
	tbl_rd_t           tbl_rd;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic              in_range_s1;

	logic [ACC_W-1:0]  acc_q;
	logic [PEND_W-1:0] pend_q;

	logic [LEN_W-1:0]   clen;
	logic [CODE_W-1:0]  code;
	logic [WIDE_W-1:0]  wide;
	logic [LEN_W-1:0]   nbits;
	logic [31:0]        aligned;
	logic [NBYTE_W-1:0] nbytes;
	logic               is_flush;
	logic               s1_push;
	logic               pkt_free;
	logic               s1_adv;

	logic               pkt_valid_q;
	logic [BYTE_W-1:0]  pkt_bytes_q [3];
	logic [NBYTE_W-1:0] pkt_left_q;
	logic [PAD_W-1:0]   pkt_pad_q;
	logic               pkt_final_q;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;
	assign in_range = ({1'b0, in_ch.symbol} < (SYM_W+1)'(SYMBOL_COUNT));
	assign len_sat  = (in_ch.code_length > LIM_LEN) ? LIM_LEN : in_ch.code_length;

	always_comb begin
		tbl_wr.en   = in_xfer && (in_ch.command == CMD_LOAD) && in_range;
		tbl_wr.idx  = in_ch.symbol;
		tbl_wr.code = in_ch.code_bits & ~({CODE_W{1'b1}} << len_sat);
		tbl_wr.len  = len_sat;
	end

	hte_code_table #(
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.rd_en  (in_xfer),
		.rd_idx (in_ch.symbol),
		.rd     (tbl_rd)
	);

	// table read stage: combine accumulator with looked-up code
	always_comb begin
		is_flush = (cmd_s1 == CMD_FLUSH);
		if ((cmd_s1 == CMD_ENCODE) && in_range_s1) begin
			clen = tbl_rd.len;
			code = tbl_rd.code;
		end else begin
			clen = '0;
			code = '0;
		end
		wide    = (WIDE_W'(acc_q) << clen) | WIDE_W'(code);
		nbits   = LEN_W'(pend_q) + clen;
		aligned = 32'(wide) << (6'd32 - {1'b0, nbits});
		case (cmd_s1)
			CMD_ENCODE: nbytes = nbits[LEN_W-1:3];
			CMD_FLUSH:  nbytes = (pend_q != '0) ? NBYTE_W'(1) : '0;
			default:    nbytes = '0;
		endcase
	end

	assign s1_push  = valid_s1 && (nbytes != '0);
	assign pkt_free = !pkt_valid_q || (out_xfer && (pkt_left_q == NBYTE_W'(1)));
	assign s1_adv   = valid_s1 && (!s1_push || pkt_free);
	assign in_ch.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			cmd_s1      <= CMD_LOAD;
			in_range_s1 <= 1'b0;
			acc_q       <= '0;
			pend_q      <= '0;
		end else begin
			if (in_xfer) begin
				valid_s1    <= 1'b1;
				cmd_s1      <= in_ch.command;
				in_range_s1 <= in_range;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				case (cmd_s1)
					CMD_ENCODE: begin
						acc_q  <= wide[ACC_W-1:0] & ~({ACC_W{1'b1}} << nbits[2:0]);
						pend_q <= nbits[2:0];
					end
					CMD_FLUSH: begin
						acc_q  <= '0;
						pend_q <= '0;
					end
					default: begin
						acc_q  <= acc_q;
						pend_q <= pend_q;
					end
				endcase
			end
		end
	end

	// byte buffer feeding out_ch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_q <= 1'b0;
			pkt_left_q  <= '0;
		end else if (s1_push && s1_adv) begin
			pkt_valid_q <= 1'b1;
			pkt_left_q  <= nbytes;
		end else if (out_xfer) begin
			if (pkt_left_q == NBYTE_W'(1)) begin
				pkt_valid_q <= 1'b0;
			end
			pkt_left_q <= pkt_left_q - NBYTE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_push && s1_adv) begin
			pkt_bytes_q[0] <= aligned[31:24];
			pkt_bytes_q[1] <= aligned[23:16];
			pkt_bytes_q[2] <= aligned[15:8];
			pkt_pad_q      <= is_flush ? PAD_W'(4'd8 - {1'b0, pend_q}) : '0;
			pkt_final_q    <= is_flush;
		end else if (out_xfer) begin
			pkt_bytes_q[0] <= pkt_bytes_q[1];
			pkt_bytes_q[1] <= pkt_bytes_q[2];
		end
	end

	assign out_ch.valid       = pkt_valid_q;
	assign out_ch.packed_byte = pkt_bytes_q[0];
	assign out_ch.pad_count   = pkt_pad_q;
	assign out_ch.is_final    = pkt_final_q;
	assign out_ch.last        = (pkt_left_q == NBYTE_W'(1));

	a_pkt_count: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid_q |-> (pkt_left_q != '0))
		else $error("byte buffer valid with no bytes left");

	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		((acc_q & ({ACC_W{1'b1}} << pend_q)) == '0))
		else $error("accumulator holds bits above the pending count");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (cmd_s1 == CMD_FLUSH)) |=> (pend_q == '0))
		else $error("flush left pending bits");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.is_final) |-> (out_ch.last && (out_ch.pad_count != '0)))
		else $error("flushed byte not marked last or without pad");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid_q && !out_xfer) |=> (pkt_valid_q && $stable(pkt_left_q)))
		else $error("byte buffer changed while output stalled");

endmodule

// File: rtl/hte_code_table.sv
// code table memory with per-entry valid bits cleared at reset
module hte_code_table import hte_pkg::*; #(
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tbl_wr_t          wr,
	input  logic             rd_en,
	input  logic [SYM_W-1:0] rd_idx,
	output tbl_rd_t          rd
);

	localparam int IDX_W = $clog2(SYMBOL_COUNT);

	tbl_rd_t                 mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] valid_q;
	tbl_rd_t                 rdata_q;
	logic                    rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx[IDX_W-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[rd_idx[IDX_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx[IDX_W-1:0]] <= '{code: wr.code, len: wr.len};
		end
		if (rd_en) begin
			rdata_q <= mem[rd_idx[IDX_W-1:0]];
		end
	end

	assign rd.code = rvalid_q ? rdata_q.code : '0;
	assign rd.len  = rvalid_q ? rdata_q.len : '0;

endmodule
